/* design/variable_record_byte_stack_defines.svh */
// ---------------------------------------------------------------------------
// variable_record_byte_stack_defines
// assertion macros used by the top-level stack design file
// ---------------------------------------------------------------------------
`ifndef VARIABLE_RECORD_BYTE_STACK_DEFINES_SVH
`define VARIABLE_RECORD_BYTE_STACK_DEFINES_SVH

`ifndef ASSERT_OFF
`define VRBS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");
`define VRBS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");
`else
`define VRBS_ASSERT(label, clk, rst_n, prop)
`define VRBS_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

/* design/vrbs_pkg.sv */
// ---------------------------------------------------------------------------
// vrbs_pkg
// types and constants of the variable record byte stack
// ---------------------------------------------------------------------------
package vrbs_pkg;

    localparam int CAPACITY_DEF         = 1024;
    localparam int HEADER_BYTES_DEF     = 1;
    localparam int MAX_RECORD_BYTES_DEF = 8;

    localparam int S_TDATA_BITS = 72;
    localparam int M_TDATA_BITS = 72;
    localparam int CMD_BITS     = 70;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_PEEK  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH_WR,
        S_RD_HDR,
        S_HDR_WAIT,
        S_CALC,
        S_RD_DATA,
        S_DATA_WAIT,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [3:0]  length;
        logic [63:0] push_data;
        op_t         operation;
    } cmd_t;

    typedef struct packed {
        logic        full_for_length;
        logic        is_empty;
        logic [3:0]  read_length;
        logic [63:0] read_data;
        status_t     status;
    } res_t;

endpackage

/* design/vrbs_ram.sv */
// ---------------------------------------------------------------------------
// vrbs_ram
// single port synchronous ram, registered read
// ---------------------------------------------------------------------------
module vrbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/vrbs_engine.sv */
// ---------------------------------------------------------------------------
// vrbs_engine
// stack sequencer: byte writes for push, header and data reads for pop/peek
// ---------------------------------------------------------------------------
module vrbs_engine
    import vrbs_pkg::*;
#(
    parameter int CAPACITY         = CAPACITY_DEF,
    parameter int HEADER_BYTES     = HEADER_BYTES_DEF,
    parameter int MAX_RECORD_BYTES = MAX_RECORD_BYTES_DEF,
    localparam int TW = $clog2(CAPACITY + 1),
    localparam int AW = $clog2(CAPACITY)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  cmd_t          cmd,
    output logic          res_valid,
    input  logic          res_ready,
    output res_t          res,
    output logic          mem_we,
    output logic          mem_re,
    output logic [AW-1:0] mem_addr,
    output logic [7:0]    mem_wdata,
    input  logic [7:0]    mem_rdata
);

    localparam logic [TW-1:0] CAP_T   = TW'(CAPACITY);
    localparam logic [TW:0]   CAP_W   = (TW+1)'(CAPACITY);
    localparam logic [3:0]    MAX_LEN = 4'(MAX_RECORD_BYTES);

    function automatic logic refuse(input logic [TW-1:0] t, input logic [3:0] l);
        logic [4:0] need;
        need = 5'(l) + 5'(HEADER_BYTES);
        return t < TW'(need);
    endfunction

    state_t        state_reg, state_next;
    logic [TW-1:0] top_reg, top_next;
    logic [TW-1:0] new_top_reg, new_top_next;
    op_t           op_reg, op_next;
    status_t       status_reg, status_next;
    logic [3:0]    len_reg, len_next;
    logic [63:0]   data_reg, data_next;
    logic [3:0]    cnt_reg, cnt_next;
    logic [3:0]    last_reg, last_next;
    logic [63:0]   hdr_reg, hdr_next;
    logic [63:0]   rbuf_reg, rbuf_next;
    logic [3:0]    stored_reg, stored_next;
    logic [3:0]    rlen_reg, rlen_next;
    logic          pend_reg, pend_next;
    logic          pend_hdr_reg, pend_hdr_next;
    logic          pend_ok_reg, pend_ok_next;
    logic [2:0]    pend_idx_reg, pend_idx_next;

    logic [3:0]    len_clamp;
    logic [3:0]    stored_calc;
    logic [3:0]    rlen_calc;
    logic [TW:0]   rd_sum;
    logic [TW:0]   pop_sum;
    logic          accept;
    logic          finish;
    logic [TW-1:0] top_after;

    assign accept    = cmd_valid && cmd_ready;
    assign finish    = (state_reg == S_FINISH) && res_ready;
    assign len_clamp = (cmd.length > MAX_LEN) ? MAX_LEN : cmd.length;

    assign stored_calc = ((|hdr_reg[63:4]) || (hdr_reg[3:0] > MAX_LEN)) ? MAX_LEN
                                                                        : hdr_reg[3:0];
    assign rlen_calc   = (len_reg < stored_calc) ? len_reg : stored_calc;

    // read address of the current header or data byte
    always_comb begin
        if (state_reg == S_RD_HDR) begin
            rd_sum = (TW+1)'(top_reg) + (TW+1)'(cnt_reg);
        end else begin
            rd_sum = (TW+1)'(top_reg) + (TW+1)'(HEADER_BYTES) + (TW+1)'(cnt_reg);
        end
    end

    assign pop_sum = (TW+1)'(top_reg) + (TW+1)'(HEADER_BYTES) + (TW+1)'(stored_reg);

    function automatic logic [TW-1:0] res_top();
        logic [TW-1:0] t;
        t = top_reg;
        if (status_reg == ST_OK) begin
            unique case (op_reg)
                OP_PUSH:  t = new_top_reg;
                OP_POP:   t = (pop_sum > CAP_W) ? CAP_T : TW'(pop_sum);
                OP_PEEK:  t = top_reg;
                OP_CLEAR: t = CAP_T;
            endcase
        end
        return t;
    endfunction

    assign top_after = res_top();

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (cmd_valid) begin
                    unique case (cmd.operation)
                        OP_PUSH: begin
                            state_next = refuse(top_reg, len_clamp) ? S_FINISH : S_PUSH_WR;
                        end
                        OP_POP, OP_PEEK: begin
                            state_next = (top_reg >= CAP_T) ? S_FINISH : S_RD_HDR;
                        end
                        OP_CLEAR: begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_PUSH_WR: begin
                if (cnt_reg == last_reg) state_next = S_FINISH;
            end
            S_RD_HDR: begin
                if (cnt_reg == last_reg) state_next = S_HDR_WAIT;
            end
            S_HDR_WAIT: begin
                state_next = S_CALC;
            end
            S_CALC: begin
                state_next = (rlen_calc == 4'd0) ? S_FINISH : S_RD_DATA;
            end
            S_RD_DATA: begin
                if (cnt_reg == last_reg) state_next = S_DATA_WAIT;
            end
            S_DATA_WAIT: begin
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (res_ready) state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        cmd_ready = (state_reg == S_IDLE);
        res_valid = (state_reg == S_FINISH);
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = '0;
        mem_wdata = '0;
        unique case (state_reg)
            S_PUSH_WR: begin
                mem_we   = 1'b1;
                mem_addr = AW'(new_top_reg + TW'(cnt_reg));
                if (5'(cnt_reg) < 5'(HEADER_BYTES)) begin
                    mem_wdata = (cnt_reg == 4'd0) ? {4'd0, len_reg} : 8'd0;
                end else begin
                    mem_wdata = data_reg[7:0];
                end
            end
            S_RD_HDR, S_RD_DATA: begin
                mem_re   = 1'b1;
                mem_addr = AW'(rd_sum);
            end
            default: begin
                mem_re = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb begin
        top_next      = top_reg;
        new_top_next  = new_top_reg;
        op_next       = op_reg;
        status_next   = status_reg;
        len_next      = len_reg;
        data_next     = data_reg;
        cnt_next      = cnt_reg;
        last_next     = last_reg;
        hdr_next      = hdr_reg;
        rbuf_next     = rbuf_reg;
        stored_next   = stored_reg;
        rlen_next     = rlen_reg;
        pend_next     = 1'b0;
        pend_hdr_next = pend_hdr_reg;
        pend_ok_next  = pend_ok_reg;
        pend_idx_next = pend_idx_reg;

        // capture the byte read in the previous cycle
        if (pend_reg) begin
            for (int b = 0; b < 8; b++) begin
                if (pend_idx_reg == 3'(b)) begin
                    if (pend_hdr_reg) begin
                        hdr_next[8*b +: 8] = pend_ok_reg ? mem_rdata : 8'd0;
                    end else begin
                        rbuf_next[8*b +: 8] = pend_ok_reg ? mem_rdata : 8'd0;
                    end
                end
            end
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    op_next      = cmd.operation;
                    len_next     = len_clamp;
                    data_next    = cmd.push_data;
                    cnt_next     = 4'd0;
                    hdr_next     = '0;
                    rbuf_next    = '0;
                    rlen_next    = 4'd0;
                    stored_next  = 4'd0;
                    status_next  = ST_OK;
                    new_top_next = top_reg - TW'(len_clamp) - TW'(HEADER_BYTES);
                    unique case (cmd.operation)
                        OP_PUSH: begin
                            if (refuse(top_reg, len_clamp)) status_next = ST_FULL;
                            last_next = 4'(5'(len_clamp) + 5'(HEADER_BYTES) - 5'd1);
                        end
                        OP_POP, OP_PEEK: begin
                            if (top_reg >= CAP_T) status_next = ST_EMPTY;
                            last_next = 4'(HEADER_BYTES - 1);
                        end
                        OP_CLEAR: begin
                            last_next = 4'd0;
                        end
                    endcase
                end
            end
            S_PUSH_WR: begin
                cnt_next = cnt_reg + 4'd1;
                if (5'(cnt_reg) >= 5'(HEADER_BYTES)) begin
                    data_next = {8'd0, data_reg[63:8]};
                end
            end
            S_RD_HDR, S_RD_DATA: begin
                pend_next     = 1'b1;
                pend_hdr_next = (state_reg == S_RD_HDR);
                pend_ok_next  = rd_sum < CAP_W;
                pend_idx_next = cnt_reg[2:0];
                cnt_next      = (cnt_reg == last_reg) ? 4'd0 : cnt_reg + 4'd1;
            end
            S_CALC: begin
                stored_next = stored_calc;
                rlen_next   = rlen_calc;
                last_next   = rlen_calc - 4'd1;
                cnt_next    = 4'd0;
            end
            default: begin
                cnt_next = cnt_reg;
            end
        endcase

        if (finish) begin
            top_next = top_after;
        end
    end

    assign res.status          = status_reg;
    assign res.read_data       = rbuf_reg;
    assign res.read_length     = rlen_reg;
    assign res.is_empty        = top_after >= CAP_T;
    assign res.full_for_length = refuse(top_after, len_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            top_reg   <= CAP_T;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            top_reg   <= top_next;
            pend_reg  <= pend_next;
        end
        new_top_reg  <= new_top_next;
        op_reg       <= op_next;
        status_reg   <= status_next;
        len_reg      <= len_next;
        data_reg     <= data_next;
        cnt_reg      <= cnt_next;
        last_reg     <= last_next;
        hdr_reg      <= hdr_next;
        rbuf_reg     <= rbuf_next;
        stored_reg   <= stored_next;
        rlen_reg     <= rlen_next;
        pend_hdr_reg <= pend_hdr_next;
        pend_ok_reg  <= pend_ok_next;
        pend_idx_reg <= pend_idx_next;
    end

endmodule

/* design/variable_record_byte_stack.sv */
// ---------------------------------------------------------------------------
// variable_record_byte_stack
// downward growing byte stack of length-prefixed records in one byte ram
// ---------------------------------------------------------------------------
//  channel   direction  payload
//  s_axis    in         operation, push_data, length
//  m_axis    out        status, read_data, read_length, is_empty, full_for_length
//
//  push writes the header bytes, then the record bytes; pop and peek read
//  the header, then copy the data bytes (none when read length is zero);
//  clear and refused or empty requests go straight to the reply; the single
//  byte port of the ram moves one byte per cycle
//  aresetn returns the stack to empty, ram contents are kept
//  a result waits in the output register while the next word is taken
// ---------------------------------------------------------------------------
`include "variable_record_byte_stack_defines.svh"

module variable_record_byte_stack
    import vrbs_pkg::*;
#(
    parameter int CAPACITY         = CAPACITY_DEF,
    parameter int HEADER_BYTES     = HEADER_BYTES_DEF,
    parameter int MAX_RECORD_BYTES = MAX_RECORD_BYTES_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // operation, push_data, length
    input  logic [S_TDATA_BITS-1:0] s_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // status, read_data, read_length, is_empty, full_for_length
    output logic [M_TDATA_BITS-1:0] m_tdata
);

    localparam int AW = $clog2(CAPACITY);

    cmd_t          cmd;
    res_t          res;
    logic          res_valid;
    logic          res_ready;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata;
    logic [7:0]    mem_rdata;
    res_t          out_reg;
    logic          out_valid_reg;
    logic          rsp_empty_st;
    logic          rsp_full_st;
    logic          rsp_has_data;
    logic          rsp_len_ok;

    assign cmd = cmd_t'(s_tdata[CMD_BITS-1:0]);

    vrbs_engine #(
        .CAPACITY         (CAPACITY),
        .HEADER_BYTES     (HEADER_BYTES),
        .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (s_tvalid),
        .cmd_ready (s_tready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_re    (mem_re),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    vrbs_ram #(
        .WIDTH (8),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_BITS'(out_reg);

    assign rsp_empty_st = out_valid_reg && (out_reg.status == ST_EMPTY);
    assign rsp_full_st  = out_valid_reg && (out_reg.status == ST_FULL);
    assign rsp_has_data = out_valid_reg && (out_reg.read_length != 4'd0);
    assign rsp_len_ok   = out_reg.read_length <= 4'(MAX_RECORD_BYTES);

    `VRBS_ASSERT(a_empty_flag, aclk, aresetn, rsp_empty_st |-> out_reg.is_empty)
    `VRBS_ASSERT(a_full_flag, aclk, aresetn, rsp_full_st |-> out_reg.full_for_length)
    `VRBS_ASSERT(a_rlen_ok, aclk, aresetn, rsp_has_data |-> (out_reg.status == ST_OK))
    `VRBS_ASSERT(a_rlen_max, aclk, aresetn, out_valid_reg |-> rsp_len_ok)

endmodule

/* tb/vrbs_reply_checker.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// vrbs_reply_checker
// watches both stream channels of the record stack, keeps its own copy of the
// byte store and top pointer, predicts the reply of every accepted command
// word and compares each accepted reply field by field in order
// ---------------------------------------------------------------------------
module vrbs_reply_checker
    import vrbs_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [S_TDATA_BITS-1:0] s_tdata,
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [M_TDATA_BITS-1:0] m_tdata,
    output int                      mismatch_count,
    output int                      replies_outstanding
);

    localparam int STACK_BYTES = CAPACITY_DEF;
    localparam int LEN_BYTES   = HEADER_BYTES_DEF;
    localparam int REC_MAX     = MAX_RECORD_BYTES_DEF;

    logic [7:0]  mirror_mem [0:STACK_BYTES-1];
    logic [10:0] mirror_top;
    res_t        pending_replies [$];
    int          mismatches  = 0;
    int          outstanding = 0;

    assign mismatch_count      = mismatches;
    assign replies_outstanding = outstanding;

    function automatic logic push_refused(input int len);
        return int'(mirror_top) < len + LEN_BYTES;
    endfunction

    function automatic res_t apply_stack_op(input cmd_t c);
        res_t        r;
        int          len;
        int          stored;
        int          base;
        int          rlen;
        int          i;
        logic [63:0] hdr;
        r    = '0;
        rlen = 0;
        len  = (int'(c.length) > REC_MAX) ? REC_MAX : int'(c.length);
        r.status = ST_OK;
        case (c.operation)
            OP_PUSH: begin
                if (push_refused(len)) begin
                    r.status = ST_FULL;
                end else begin
                    mirror_top = mirror_top - 11'(len);
                    for (i = 0; i < len; i++)
                        mirror_mem[int'(mirror_top) + i] = c.push_data[8*i +: 8];
                    mirror_top = mirror_top - 11'(LEN_BYTES);
                    for (i = 0; i < LEN_BYTES; i++)
                        mirror_mem[int'(mirror_top) + i] = (i < 4) ? 8'(len >> (8 * i)) : 8'd0;
                end
            end
            OP_POP, OP_PEEK: begin
                if (int'(mirror_top) >= STACK_BYTES) begin
                    r.status = ST_EMPTY;
                end else begin
                    hdr = '0;
                    for (i = 0; i < LEN_BYTES && i < 8; i++)
                        hdr = hdr | (64'(mirror_mem[int'(mirror_top) + i]) << (8 * i));
                    stored = (hdr > 64'(REC_MAX)) ? REC_MAX : int'(hdr);
                    base   = int'(mirror_top) + LEN_BYTES;
                    rlen   = (len < stored) ? len : stored;
                    for (i = 0; i < rlen; i++)
                        r.read_data[8*i +: 8] = mirror_mem[base + i];
                    if (c.operation == OP_POP)
                        mirror_top = (base + stored > STACK_BYTES) ? 11'(STACK_BYTES)
                                                                   : 11'(base + stored);
                end
            end
            default: begin
                mirror_top = 11'(STACK_BYTES);
            end
        endcase
        r.read_length     = 4'(rlen);
        r.is_empty        = int'(mirror_top) >= STACK_BYTES;
        r.full_for_length = push_refused(len);
        return r;
    endfunction

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            if (mismatches < 10)
                $display("mismatch in %s: expected %0h, got %0h", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        res_t want;
        res_t got;
        if (!aresetn) begin
            mirror_top = 11'(STACK_BYTES);
            pending_replies.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = res_t'(m_tdata);
                if (pending_replies.size() == 0) begin
                    if (mismatches < 10)
                        $display("reply word %0h with nothing expected", m_tdata);
                    mismatches++;
                end else begin
                    want = pending_replies.pop_front();
                    check_field("status", 64'(want.status), 64'(got.status));
                    check_field("read_data", want.read_data, got.read_data);
                    check_field("read_length", 64'(want.read_length), 64'(got.read_length));
                    check_field("is_empty", 64'(want.is_empty), 64'(got.is_empty));
                    check_field("full_for_length", 64'(want.full_for_length),
                                64'(got.full_for_length));
                end
            end
            if (s_tvalid && s_tready)
                pending_replies.push_back(apply_stack_op(cmd_t'(s_tdata[CMD_BITS-1:0])));
        end
        outstanding = pending_replies.size();
    end

endmodule

/* tb/variable_record_byte_stack_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// variable_record_byte_stack_tb
// drives push, pop, peek and clear words into the record stack: a directed
// run over the edge cases, a fill to overflow, a drain past empty, then
// random segments with shifting push bias; bursty sender, stalling receiver
// ---------------------------------------------------------------------------
module variable_record_byte_stack_tb;
    import vrbs_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic                    aclk     = 1'b0;
    logic                    aresetn  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata  = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_BITS-1:0] m_tdata;

    int mismatches;
    int outstanding;
    int cycles      = 0;
    int burst_left  = 0;
    int ready_mode  = 0;
    int ready_phase = 0;
    int stall_left  = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    variable_record_byte_stack DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    vrbs_reply_checker checker_i (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_tvalid            (s_tvalid),
        .s_tready            (s_tready),
        .s_tdata             (s_tdata),
        .m_tvalid            (m_tvalid),
        .m_tready            (m_tready),
        .m_tdata             (m_tdata),
        .mismatch_count      (mismatches),
        .replies_outstanding (outstanding)
    );

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver back-pressure with a randomly changing pattern
    always @(negedge aclk) begin
        if (ready_phase % 50 == 0)
            ready_mode = $urandom_range(0, 3);
        ready_phase++;
        case (ready_mode)
            0: m_tready = 1'b1;
            1: m_tready = (ready_phase % 3 == 0);
            2: m_tready = 1'($urandom_range(0, 1));
            default: begin
                if (stall_left == 0) begin
                    m_tready   = !m_tready;
                    stall_left = $urandom_range(1, 8);
                end else begin
                    stall_left--;
                end
            end
        endcase
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic issue(input op_t op, input logic [63:0] bytes_in, input logic [3:0] len);
        cmd_t c;
        int   gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        c.operation = op;
        c.push_data = bytes_in;
        c.length    = len;
        s_tdata  = {{(S_TDATA_BITS-CMD_BITS){1'b0}}, c};
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    initial begin
        int         i;
        int         pick;
        int         push_pct;
        op_t        op;
        logic [3:0] len;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        // edge cases
        issue(OP_POP,   64'd0, 4'd4);
        issue(OP_PEEK,  64'd0, 4'd8);
        issue(OP_PUSH,  {$urandom, $urandom}, 4'd0);
        issue(OP_PEEK,  64'd0, 4'd15);
        issue(OP_POP,   64'd0, 4'd3);
        issue(OP_PUSH,  64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
        issue(OP_PUSH,  64'd0, 4'd8);
        issue(OP_PUSH,  {$urandom, $urandom}, 4'd15);
        issue(OP_PEEK,  64'd0, 4'd15);
        issue(OP_PEEK,  64'd0, 4'd0);
        issue(OP_PEEK,  64'd0, 4'd3);
        issue(OP_POP,   64'd0, 4'd2);
        issue(OP_POP,   64'd0, 4'd8);
        issue(OP_PUSH,  {$urandom, $urandom}, 4'd1);
        issue(OP_PUSH,  64'hFFFF_FFFF_FFFF_FFFF, 4'd9);
        issue(OP_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
        issue(OP_POP,   64'd0, 4'd8);
        issue(OP_PEEK,  64'd0, 4'd8);
        issue(OP_PUSH,  {$urandom, $urandom}, 4'd5);
        issue(OP_POP,   64'd0, 4'd15);
        issue(OP_CLEAR, 64'd0, 4'd0);

        // drain everything before going on
        s_tvalid   = 1'b0;
        burst_left = 0;
        while (outstanding != 0) @(negedge aclk);

        // fill until pushes are refused
        for (i = 0; i < 140; i++)
            issue(OP_PUSH, {$urandom, $urandom}, (i < 110) ? 4'd8 : 4'($urandom_range(0, 15)));

        // drain past empty
        for (i = 0; i < 130; i++)
            issue(($urandom_range(0, 2) == 0) ? OP_PEEK : OP_POP, {$urandom, $urandom},
                  4'($urandom_range(0, 15)));

        // random segments with a shifting push bias
        push_pct = 45;
        for (i = 0; i < 460; i++) begin
            if (i % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0: push_pct = 70;
                    1: push_pct = 45;
                    default: push_pct = 25;
                endcase
            end
            pick = $urandom_range(0, 99);
            if (pick < 2)
                op = OP_CLEAR;
            else if (pick < 2 + push_pct)
                op = OP_PUSH;
            else if (pick < 2 + push_pct + (98 - push_pct) / 2)
                op = OP_POP;
            else
                op = OP_PEEK;
            len = ($urandom_range(0, 6) == 0) ? 4'($urandom_range(9, 15))
                                              : 4'($urandom_range(0, 8));
            issue(op, {$urandom, $urandom}, len);
        end

        s_tvalid = 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (30) @(negedge aclk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
